// ===== rtl/bfla_pkg.sv =====
// ----------------------------------------------------------------------------
// Bucketed free-list allocator package
// Operation and status codes and default sizes used by the top and testbench.
// ----------------------------------------------------------------------------
package bfla_pkg;

   localparam int DEF_SLOTS_PER_BUCKET = 16;
   localparam int DEF_MAX_BUCKETS      = 16;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_SPACE   = 2'd1,
      ST_BAD_HANDLE = 2'd2
   } status_type;

endpackage

// ===== rtl/bfla_link_ram.sv =====
// ----------------------------------------------------------------------------
// Free-list link memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bfla_link_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bucketed_free_list_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Bucketed free-list allocator
// Hands out (bucket, slot) handles from a linked free list held in memory.
// ----------------------------------------------------------------------------
// Usage: each req word carries an operation in req_tuser (allocate, free,
// release, no-op) and, for a free, the handle in req_tdata. Every request gives
// exactly one rsp word: the status in rsp_tuser and the allocated handle in
// rsp_tdata (zero unless an allocation succeeded).
// Sequence: a free, a release, a no-op or a failed allocation is answered
// straight from the idle state. An allocation from a non-empty list first
// reads the link of the list head from the registered link memory. An
// allocation from an empty list first links a fresh bucket, one link write
// a cycle. One request is in work at a time.
// Reset empties the list and returns every bucket; the link memory is not
// cleared, since a link is always written before it is read.
// When the receiver stalls, a finished word waits in the rsp register and a
// further request may still be taken; its result is then held internally,
// and req_tready stays low until the rsp register has been emptied.
// ----------------------------------------------------------------------------
module bucketed_free_list_allocator_top #(
   parameter int SLOTS_PER_BUCKET = bfla_pkg::DEF_SLOTS_PER_BUCKET,
   parameter int MAX_BUCKETS      = bfla_pkg::DEF_MAX_BUCKETS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [3:0] free_bucket, [7:4] free_slot
   input  logic [1:0] req_tuser,   // [1:0] opcode
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [3:0] alloc_bucket, [7:4] alloc_slot
   output logic [1:0] rsp_tuser    // [1:0] status
);

   import bfla_pkg::*;

   localparam int DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;
   localparam int IW    = $clog2(DEPTH);
   localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SW    = $clog2(SLOTS_PER_BUCKET);
   localparam int CW    = $clog2(MAX_BUCKETS + 1);
   localparam int LW    = 1 + BW + SW;

   localparam logic [IW-1:0] SPB_IDX   = IW'(SLOTS_PER_BUCKET);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS_PER_BUCKET - 1);
   localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_BUCKETS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_FILL,
      S_RESP
   } state_type;

   function automatic logic [IW-1:0] link_idx(input logic [BW-1:0] b,
                                              input logic [SW-1:0] s);
      return IW'(b) * SPB_IDX + IW'(s);
   endfunction

   state_type     state_ff, state_in;
   logic          head_valid_ff, head_valid_in;
   logic [BW-1:0] head_bucket_ff, head_bucket_in;
   logic [SW-1:0] head_slot_ff, head_slot_in;
   logic [CW-1:0] issued_ff, issued_in;
   logic [SW-1:0] fill_ff, fill_in;
   logic [7:0]    pend_tdata_ff, pend_tdata_in;
   logic [1:0]    pend_tuser_ff, pend_tuser_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]    rsp_tuser_ff, rsp_tuser_in;

   logic          mem_we, mem_re;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [LW-1:0] mem_wdata, mem_rdata;

   opcode_type    req_op;
   logic [3:0]    free_bucket, free_slot;
   logic          accept, rsp_free, handle_ok;
   logic [BW-1:0] new_bucket;
   logic          done;
   logic [7:0]    done_tdata;
   logic [1:0]    done_tuser;

   assign req_op      = opcode_type'(req_tuser);
   assign free_bucket = req_tdata[3:0];
   assign free_slot   = req_tdata[7:4];
   assign req_tready  = (state_ff == S_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign new_bucket  = BW'(issued_ff);
   assign handle_ok   = (16'(free_bucket) < 16'(issued_ff)) &&
                        (16'(free_slot) < 16'(SLOTS_PER_BUCKET));

   always_comb begin
      state_in       = state_ff;
      head_valid_in  = head_valid_ff;
      head_bucket_in = head_bucket_ff;
      head_slot_in   = head_slot_ff;
      issued_in      = issued_ff;
      fill_in        = fill_ff;
      pend_tdata_in  = pend_tdata_ff;
      pend_tuser_in  = pend_tuser_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tuser_in   = rsp_tuser_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = link_idx(BW'(free_bucket), SW'(free_slot));
      mem_wdata      = {head_valid_ff, head_bucket_ff, head_slot_ff};
      mem_raddr      = link_idx(head_bucket_ff, head_slot_ff);
      done           = 1'b0;
      done_tdata     = 8'd0;
      done_tuser     = ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_ALLOC: begin
                     if (head_valid_ff) begin
                        mem_re   = 1'b1;
                        state_in = S_POP;
                     end else if (issued_ff < MAX_CNT) begin
                        fill_in  = '0;
                        state_in = S_FILL;
                     end else begin
                        done       = 1'b1;
                        done_tuser = ST_NO_SPACE;
                     end
                  end
                  OP_FREE: begin
                     done = 1'b1;
                     if (handle_ok) begin
                        // Push the freed handle; its link takes the old head.
                        mem_we         = 1'b1;
                        head_valid_in  = 1'b1;
                        head_bucket_in = BW'(free_bucket);
                        head_slot_in   = SW'(free_slot);
                     end else begin
                        done_tuser = ST_BAD_HANDLE;
                     end
                  end
                  OP_RELEASE: begin
                     done           = 1'b1;
                     head_valid_in  = 1'b0;
                     head_bucket_in = '0;
                     head_slot_in   = '0;
                     issued_in      = '0;
                  end
                  OP_NOP: begin
                     done = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_tuser_in   = ST_OK;
               rsp_tdata_in   = {4'(head_slot_ff), 4'(head_bucket_ff)};
               head_valid_in  = mem_rdata[LW-1];
               head_bucket_in = mem_rdata[LW-1] ? mem_rdata[SW +: BW] : '0;
               head_slot_in   = mem_rdata[LW-1] ? mem_rdata[SW-1:0] : '0;
               state_in       = S_IDLE;
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = link_idx(new_bucket, fill_ff);
            fill_in   = SW'(fill_ff + SW'(1));
            if (fill_ff == LAST_SLOT) begin
               // The last slot links to the old (empty) list. Slot 0 is then
               // popped at once; its link is known to be slot 1 of the bucket.
               mem_wdata      = {head_valid_ff, head_bucket_ff, head_slot_ff};
               head_valid_in  = 1'b1;
               head_bucket_in = new_bucket;
               head_slot_in   = SW'(1);
               issued_in      = CW'(issued_ff + 1'b1);
               state_in       = S_IDLE;
               done           = 1'b1;
               done_tdata     = {4'd0, 4'(new_bucket)};
            end else begin
               mem_wdata = {1'b1, new_bucket, SW'(fill_ff + SW'(1))};
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = pend_tdata_ff;
               rsp_tuser_in = pend_tuser_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (done) begin
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_tdata_in = done_tdata;
            rsp_tuser_in = done_tuser;
         end else begin
            pend_tdata_in = done_tdata;
            pend_tuser_in = done_tuser;
            state_in      = S_RESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         head_valid_ff  <= 1'b0;
         head_bucket_ff <= '0;
         head_slot_ff   <= '0;
         issued_ff      <= '0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_valid_ff  <= head_valid_in;
         head_bucket_ff <= head_bucket_in;
         head_slot_ff   <= head_slot_in;
         issued_ff      <= issued_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pend_tdata_ff <= pend_tdata_in;
      pend_tuser_ff <= pend_tuser_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   bfla_link_ram #(
      .DEPTH (DEPTH),
      .AW    (IW),
      .DW    (LW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== verif/bucketed_free_list_allocator_top_test.sv =====
// ----------------------------------------------------------------------------
// Bucketed free-list allocator testbench
// A short scripted sequence and then random phases of allocation, freeing,
// pool filling, release and malformed words are driven into the allocator.
// A behavioural copy of the free list predicts each reply the script leaves
// open; each reply is compared field by field with the oldest expected reply.
// ----------------------------------------------------------------------------
module bucketed_free_list_allocator_top_test;
   import bfla_pkg::*;

   localparam int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET;
   localparam int MAX_BUCKETS      = DEF_MAX_BUCKETS;
   localparam int LINK_DEPTH       = SLOTS_PER_BUCKET * MAX_BUCKETS;
   localparam int RANDOM_WORDS     = 1900;
   localparam int HOLD_CYCLES      = 64;
   localparam int STALL_LIMIT      = 1000;
   localparam int SETTLE_CYCLES    = 2 * SLOTS_PER_BUCKET;
   localparam int MAX_REPORTS      = 50;

   typedef struct packed {
      status_type status;
      logic [3:0] bucket;
      logic [3:0] slot;
   } pool_reply_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] bucket;
      logic [3:0] slot;
   } free_link_type;

   typedef struct packed {
      opcode_type     op;
      logic [3:0]     fb;
      logic [3:0]     fs;
      logic           typed;
      pool_reply_type want;
   } script_row_type;

   // Rows with typed set carry a reply that can be read straight off the list;
   // the others are left to the predictor.
   localparam script_row_type DIRECTED_SCRIPT [22] = '{
      '{OP_FREE,    4'd0,  4'd0,  1'b1, '{ST_BAD_HANDLE, 4'd0, 4'd0}},
      '{OP_NOP,     4'd15, 4'd15, 1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_ALLOC,   4'd0,  4'd0,  1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_ALLOC,   4'd15, 4'd15, 1'b1, '{ST_OK,         4'd0, 4'd1}},
      '{OP_FREE,    4'd1,  4'd0,  1'b1, '{ST_BAD_HANDLE, 4'd0, 4'd0}},
      '{OP_FREE,    4'd15, 4'd15, 1'b1, '{ST_BAD_HANDLE, 4'd0, 4'd0}},
      '{OP_FREE,    4'd0,  4'd0,  1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_ALLOC,   4'd0,  4'd0,  1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_FREE,    4'd0,  4'd1,  1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_FREE,    4'd0,  4'd1,  1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_ALLOC,   4'd0,  4'd0,  1'b1, '{ST_OK,         4'd0, 4'd1}},
      '{OP_ALLOC,   4'd0,  4'd0,  1'b0, '{ST_OK,         4'd0, 4'd0}},
      '{OP_RELEASE, 4'd15, 4'd15, 1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_FREE,    4'd0,  4'd3,  1'b1, '{ST_BAD_HANDLE, 4'd0, 4'd0}},
      '{OP_ALLOC,   4'd0,  4'd0,  1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_ALLOC,   4'd0,  4'd0,  1'b0, '{ST_OK,         4'd0, 4'd0}},
      '{OP_FREE,    4'd0,  4'd15, 1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_ALLOC,   4'd0,  4'd0,  1'b1, '{ST_OK,         4'd0, 4'd15}},
      '{OP_ALLOC,   4'd0,  4'd0,  1'b0, '{ST_OK,         4'd0, 4'd0}},
      '{OP_NOP,     4'd10, 4'd5,  1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_RELEASE, 4'd0,  4'd0,  1'b1, '{ST_OK,         4'd0, 4'd0}},
      '{OP_FREE,    4'd0,  4'd0,  1'b1, '{ST_BAD_HANDLE, 4'd0, 4'd0}}
   };

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [3:0] free_bucket, [7:4] free_slot
   logic [1:0] req_tuser;   // [1:0] opcode
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [3:0] alloc_bucket, [7:4] alloc_slot
   logic [1:0] rsp_tuser;   // [1:0] status

   // Behavioural copy of the free list.
   logic          fl_head_valid;
   logic [3:0]    fl_head_bucket;
   logic [3:0]    fl_head_slot;
   int unsigned   fl_buckets_issued;
   free_link_type link_mem [LINK_DEPTH];

   pool_reply_type pending_replies[$];
   logic [7:0]     held_handles[$];   // {slot, bucket} of handles out on loan
   logic [7:0]     last_freed;
   int unsigned    words_sent;
   int unsigned    replies_checked;
   int unsigned    mismatch_count;
   int unsigned    stalled_cycles;
   int unsigned    sender_gap_max;
   bit             rsp_hold_request;
   pool_reply_type oldest_reply;

   bucketed_free_list_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic pool_reply_type apply_pool_op(opcode_type op, logic [3:0] fb,
                                                    logic [3:0] fs);
      pool_reply_type r;
      free_link_type  successor;
      logic [3:0]     nb;
      r = '{status: ST_OK, bucket: 4'd0, slot: 4'd0};
      case (op)
         OP_ALLOC: begin
            // An empty list is refilled from a fresh bucket, linked in slot order,
            // whose last slot points at the old head.
            if (!fl_head_valid && fl_buckets_issued < MAX_BUCKETS) begin
               nb = 4'(fl_buckets_issued);
               for (int i = 0; i < SLOTS_PER_BUCKET - 1; i++)
                  link_mem[{nb, 4'(i)}] = '{1'b1, nb, 4'(i + 1)};
               link_mem[{nb, 4'(SLOTS_PER_BUCKET - 1)}] =
                  '{fl_head_valid, fl_head_bucket, fl_head_slot};
               fl_head_valid  = 1'b1;
               fl_head_bucket = nb;
               fl_head_slot   = 4'd0;
               fl_buckets_issued++;
            end
            if (!fl_head_valid) begin
               r.status = ST_NO_SPACE;
            end else begin
               r.bucket       = fl_head_bucket;
               r.slot         = fl_head_slot;
               successor      = link_mem[{fl_head_bucket, fl_head_slot}];
               fl_head_valid  = successor.valid;
               fl_head_bucket = successor.valid ? successor.bucket : 4'd0;
               fl_head_slot   = successor.valid ? successor.slot : 4'd0;
            end
         end
         OP_FREE: begin
            if (fb >= fl_buckets_issued || fs >= SLOTS_PER_BUCKET) begin
               r.status = ST_BAD_HANDLE;
            end else begin
               link_mem[{fb, fs}] = '{fl_head_valid, fl_head_bucket, fl_head_slot};
               fl_head_valid  = 1'b1;
               fl_head_bucket = fb;
               fl_head_slot   = fs;
            end
         end
         OP_RELEASE: begin
            fl_head_valid     = 1'b0;
            fl_head_bucket    = 4'd0;
            fl_head_slot      = 4'd0;
            fl_buckets_issued = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_REPORTS)
         $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Offers one word after a random gap and waits for it to be taken. The valid
   // is only lowered when a gap follows, so back-to-back words keep it high.
   task automatic issue_word(input opcode_type op, input logic [3:0] fb,
                             input logic [3:0] fs, input logic typed,
                             input pool_reply_type want, output pool_reply_type reply);
      int unsigned gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {fs, fb};
      do @(posedge clock); while (!req_tready);
      reply = apply_pool_op(op, fb, fs);
      pending_replies.push_back(typed ? want : reply);
      if (op == OP_ALLOC && reply.status == ST_OK)
         held_handles.push_back({reply.slot, reply.bucket});
      if (op == OP_FREE && reply.status == ST_OK)
         last_freed = {fs, fb};
      if (op == OP_RELEASE)
         held_handles.delete();
      words_sent++;
   endtask

   task automatic send_op(opcode_type op, logic [3:0] fb, logic [3:0] fs);
      pool_reply_type reply;
      issue_word(op, fb, fs, 1'b0, '0, reply);
   endtask

   task automatic free_held();
      int unsigned idx;
      logic [7:0]  h;
      idx = $urandom_range(0, held_handles.size() - 1);
      h   = held_handles[idx];
      held_handles.delete(idx);
      send_op(OP_FREE, h[3:0], h[7:4]);
   endtask

   // Malformed or unusual words: any operation with random fields, a double
   // free, a free naming a bucket not yet issued, and the unused operation.
   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_op(opcode_type'($urandom_range(0, 3)), 4'($urandom), 4'($urandom));
         1: send_op(OP_FREE, last_freed[3:0], last_freed[7:4]);
         2: send_op(OP_FREE, (fl_buckets_issued < MAX_BUCKETS) ?
                    4'($urandom_range(fl_buckets_issued, MAX_BUCKETS - 1)) :
                    4'($urandom), 4'($urandom));
         default: send_op(OP_NOP, 4'($urandom), 4'($urandom));
      endcase
   endtask

   task automatic run_churn(int unsigned count);
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            send_noise();
         else if (pick < 52 || held_handles.size() == 0)
            send_op(OP_ALLOC, 4'($urandom), 4'($urandom));
         else
            free_held();
      end
   endtask

   // Allocates until the pool has refused twice, then hands half the loans back.
   task automatic run_fill();
      pool_reply_type reply;
      int unsigned    refusals;
      int unsigned    tries;
      refusals = 0;
      tries    = 0;
      while (refusals < 2 && tries < LINK_DEPTH + 8) begin
         issue_word(OP_ALLOC, 4'($urandom), 4'($urandom), 1'b0, '0, reply);
         if (reply.status == ST_NO_SPACE)
            refusals++;
         tries++;
      end
      repeat (held_handles.size() / 2) free_held();
   endtask

   task automatic run_release();
      if ($urandom_range(0, 1) == 1)
         while (held_handles.size() != 0) free_held();
      send_op(OP_RELEASE, 4'($urandom), 4'($urandom));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // The receiver draws its stall before every word; a hold request from the
   // sender replaces one draw by a long stretch so that the allocator backs up.
   task automatic take_replies();
      int unsigned stall;
      int unsigned stall_max;
      int unsigned taken;
      stall_max = 9;
      taken     = 0;
      forever begin
         if (taken % 32 == 0)
            stall_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
         taken++;
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end else begin
            stall = $urandom_range(0, stall_max);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("reply with nothing pending, tuser %0d tdata %0h",
                                      rsp_tuser, rsp_tdata));
         end else begin
            oldest_reply = pending_replies.pop_front();
            if (rsp_tuser != oldest_reply.status)
               report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                               replies_checked, rsp_tuser, oldest_reply.status));
            if (rsp_tdata[3:0] != oldest_reply.bucket)
               report_mismatch($sformatf("reply %0d bucket %0d, expected %0d",
                               replies_checked, rsp_tdata[3:0], oldest_reply.bucket));
            if (rsp_tdata[7:4] != oldest_reply.slot)
               report_mismatch($sformatf("reply %0d slot %0d, expected %0d",
                               replies_checked, rsp_tdata[7:4], oldest_reply.slot));
         end
         replies_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles == STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      pool_reply_type reply;
      int unsigned    phase;
      int unsigned    pick;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'd0;
      req_tuser  <= OP_NOP;
      rsp_tready <= 1'b0;
      fl_head_valid     = 1'b0;
      fl_head_bucket    = 4'd0;
      fl_head_slot      = 4'd0;
      fl_buckets_issued = 0;
      last_freed        = 8'd0;
      words_sent        = 0;
      replies_checked   = 0;
      mismatch_count    = 0;
      stalled_cycles    = 0;
      sender_gap_max    = 9;
      rsp_hold_request  = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      fork
         take_replies();
      join_none

      for (int i = 0; i < $size(DIRECTED_SCRIPT); i++)
         issue_word(DIRECTED_SCRIPT[i].op, DIRECTED_SCRIPT[i].fb, DIRECTED_SCRIPT[i].fs,
                    DIRECTED_SCRIPT[i].typed, DIRECTED_SCRIPT[i].want, reply);

      // The first random phase runs back to back into a long receiver hold;
      // the second fills the pool until it runs out of buckets.
      phase = 0;
      while (words_sent < $size(DIRECTED_SCRIPT) + RANDOM_WORDS) begin
         sender_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         if (phase == 0) begin
            sender_gap_max   = 0;
            rsp_hold_request = 1'b1;
            run_churn(24);
         end else if (phase == 1) begin
            run_fill();
         end else begin
            if ($urandom_range(0, 11) == 0)
               rsp_hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 4)
               run_fill();
            else if (pick < 12)
               run_release();
            else if (pick < 22)
               repeat ($urandom_range(10, 20)) send_noise();
            else
               run_churn($urandom_range(20, 60));
         end
         if (phase == 0 || $urandom_range(0, 3) == 0)
            wait_for_drain();
         phase++;
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
